### rtl/utwb_pkg.sv
// shared types, constants and helpers for the utf-8 word wrap line breaker
// no dependencies; used by every module under rtl
package utwb_pkg;

	// field and port widths
	localparam int BYTE_W            = 8;
	localparam int OUT_W             = 16;
	localparam int CP_W              = 21;
	localparam int CELL_W            = 9;
	localparam int WIDTH_W           = 8;
	localparam int PEND_W            = 2;
	localparam int MAX_LINES         = 3;
	localparam int LINE_CNT_W        = 2;
	localparam int INDEX_BITS_DEFAULT = 16;

	// configuration port
	localparam int ADDR_W            = 3;
	localparam int DATA_W            = 32;
	localparam int REG_IDX_W         = 1;
	localparam logic [REG_IDX_W-1:0] REG_WRAP_WIDTH = 1'b0;
	localparam logic [WIDTH_W-1:0]   WRAP_WIDTH_RESET = 8'd80;

	// special codepoints
	localparam logic [CP_W-1:0] CP_TAB     = 21'h00009;
	localparam logic [CP_W-1:0] CP_NEWLINE = 21'h0000A;
	localparam logic [CP_W-1:0] CP_SPACE   = 21'h00020;

	// double-width ranges
	localparam logic [CP_W-1:0] CJK_LO   = 21'h04E00;
	localparam logic [CP_W-1:0] CJK_HI   = 21'h09FFF;
	localparam logic [CP_W-1:0] PUNCT_LO = 21'h03000;
	localparam logic [CP_W-1:0] PUNCT_HI = 21'h0303F;
	localparam logic [CP_W-1:0] FULL_LO  = 21'h0FF00;
	localparam logic [CP_W-1:0] FULL_HI  = 21'h0FFEF;

	// utf-8 lead byte classes
	localparam logic [BYTE_W-1:0] LEAD2_MASK = 8'hE0;
	localparam logic [BYTE_W-1:0] LEAD2_CODE = 8'hC0;
	localparam logic [BYTE_W-1:0] LEAD3_MASK = 8'hF0;
	localparam logic [BYTE_W-1:0] LEAD3_CODE = 8'hE0;
	localparam logic [BYTE_W-1:0] LEAD4_MASK = 8'hF8;
	localparam logic [BYTE_W-1:0] LEAD4_CODE = 8'hF0;
	localparam logic [BYTE_W-1:0] CONT_BITS  = 8'h3F;
	localparam logic [BYTE_W-1:0] LEAD2_BITS = 8'h1F;
	localparam logic [BYTE_W-1:0] LEAD3_BITS = 8'h0F;
	localparam logic [BYTE_W-1:0] LEAD4_BITS = 8'h07;

	// one accepted input item
	typedef struct packed {
		logic [BYTE_W-1:0] value;
		logic              has;
		logic              last;
	} item_t;

	// decoded codepoint
	typedef struct packed {
		logic            valid;
		logic [CP_W-1:0] value;
	} cp_t;

	// one reported line
	typedef struct packed {
		logic [OUT_W-1:0] start;
		logic [OUT_W-1:0] length;
		logic             last;
	} line_t;

	// display cells taken by a codepoint
	function automatic logic [1:0] cell_width(input logic [CP_W-1:0] c);
		logic wide;
		wide = ((c >= CJK_LO) && (c <= CJK_HI)) ||
			((c >= PUNCT_LO) && (c <= PUNCT_HI)) ||
			((c >= FULL_LO) && (c <= FULL_HI));
		return wide ? 2'd2 : 2'd1;
	endfunction

endpackage

### rtl/utwb_decode.sv
// utf-8 decoder: continuation count and partial codepoint
// depends on utwb_pkg
module utwb_decode (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           go,
	input  utwb_pkg::item_t item,
	output utwb_pkg::cp_t  cp
);

	logic [utwb_pkg::PEND_W-1:0] pend_q, pend_d;
	logic [utwb_pkg::CP_W-1:0]   part_q, part_d;
	logic [utwb_pkg::CP_W-1:0]   shifted;

	assign shifted = {part_q[utwb_pkg::CP_W-7:0], item.value[5:0]};

	// next decoder state and completed codepoint
	always_comb begin
		pend_d   = pend_q;
		part_d   = part_q;
		cp.valid = 1'b0;
		cp.value = shifted;
		if (item.has) begin
			if (pend_q != '0) begin
				part_d = shifted;
				pend_d = pend_q - 1'b1;
				cp.valid = (pend_q == 2'd1);
			end else if (item.value[7] == 1'b0) begin
				cp.valid = 1'b1;
				cp.value = utwb_pkg::CP_W'(item.value);
			end else if ((item.value & utwb_pkg::LEAD2_MASK) == utwb_pkg::LEAD2_CODE) begin
				part_d = utwb_pkg::CP_W'(item.value & utwb_pkg::LEAD2_BITS);
				pend_d = 2'd1;
			end else if ((item.value & utwb_pkg::LEAD3_MASK) == utwb_pkg::LEAD3_CODE) begin
				part_d = utwb_pkg::CP_W'(item.value & utwb_pkg::LEAD3_BITS);
				pend_d = 2'd2;
			end else if ((item.value & utwb_pkg::LEAD4_MASK) == utwb_pkg::LEAD4_CODE) begin
				part_d = utwb_pkg::CP_W'(item.value & utwb_pkg::LEAD4_BITS);
				pend_d = 2'd3;
			end
		end
		// a cut-short sequence is dropped at the end of the paragraph
		if (item.last) begin
			pend_d = '0;
			part_d = '0;
		end
	end

	// decoder state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
			part_q <= '0;
		end else if (go) begin
			pend_q <= pend_d;
			part_q <= part_d;
		end
	end

endmodule

### rtl/utwb_wrap.sv
// greedy line breaker: line state and up to three lines per item
// depends on utwb_pkg
module utwb_wrap #(
	parameter int INDEX_BITS = utwb_pkg::INDEX_BITS_DEFAULT
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              go,
	input  utwb_pkg::item_t                   item,
	input  utwb_pkg::cp_t                     cp,
	input  logic [utwb_pkg::WIDTH_W-1:0]      wrap_width,
	output utwb_pkg::line_t                   res [utwb_pkg::MAX_LINES],
	output logic [utwb_pkg::LINE_CNT_W-1:0]   res_cnt
);

	localparam logic [INDEX_BITS-1:0] IDX_MAX = {INDEX_BITS{1'b1}};
	localparam logic [INDEX_BITS-1:0] IDX_ONE = {{(INDEX_BITS-1){1'b0}}, 1'b1};

	typedef logic [INDEX_BITS-1:0]       idx_t;
	typedef logic [utwb_pkg::CELL_W-1:0] cells_t;

	function automatic idx_t inc_sat(input idx_t v);
		return (v == IDX_MAX) ? v : v + IDX_ONE;
	endfunction

	function automatic idx_t sub_clamp(input idx_t a, input idx_t b);
		return (a > b) ? a - b : '0;
	endfunction

	// state
	idx_t   cnt_q, ls_q, bpos_q;
	cells_t cells_q, cab_q;
	logic   btab_q, bval_q, held_q, anyb_q;

	// next state
	idx_t   cnt_d, ls_d, bpos_d, idx;
	cells_t cells_d, cab_d, nw, w9;
	logic   btab_d, bval_d, held_d, anyb_d;
	logic   blank, done;
	logic [utwb_pkg::LINE_CNT_W-1:0] n;

	assign w9    = utwb_pkg::CELL_W'(utwb_pkg::cell_width(cp.value));
	assign blank = (cp.value == utwb_pkg::CP_SPACE) || (cp.value == utwb_pkg::CP_TAB);
	assign idx   = cnt_q;

	// one item: held space, newline or placement, then paragraph end
	always_comb begin
		cnt_d   = cnt_q;
		ls_d    = ls_q;
		bpos_d  = bpos_q;
		cells_d = cells_q;
		cab_d   = cab_q;
		btab_d  = btab_q;
		bval_d  = bval_q;
		held_d  = held_q;
		anyb_d  = anyb_q;
		nw      = '0;
		done    = 1'b0;
		n       = '0;
		for (int k = 0; k < utwb_pkg::MAX_LINES; k++) begin
			res[k] = '0;
		end

		if (go && cp.valid) begin
			cnt_d = inc_sat(cnt_q);
			if (wrap_width != '0) begin
				// line ended by a skipped space comes out now
				if (held_d) begin
					if (n != 2'd3) begin
						res[n] = '{utwb_pkg::OUT_W'(ls_d),
							utwb_pkg::OUT_W'(sub_clamp(sub_clamp(idx, IDX_ONE), ls_d)), 1'b0};
						n = n + 2'd1;
					end
					ls_d    = idx;
					cells_d = '0;
					bval_d  = 1'b0;
					held_d  = 1'b0;
				end
				if (cp.value == utwb_pkg::CP_NEWLINE) begin
					// forced break
					if (n != 2'd3) begin
						res[n] = '{utwb_pkg::OUT_W'(ls_d),
							utwb_pkg::OUT_W'(sub_clamp(idx, ls_d)), 1'b0};
						n = n + 2'd1;
					end
					ls_d    = inc_sat(idx);
					cells_d = '0;
					bval_d  = 1'b0;
				end else begin
					// placement: at most three passes settle the glyph
					for (int p = 0; p < utwb_pkg::MAX_LINES; p++) begin
						if (!done) begin
							nw = cells_d + w9;
							if (nw <= {1'b0, wrap_width}) begin
								cells_d = nw;
								if (blank && (idx > ls_d)) begin
									bval_d = 1'b1;
									bpos_d = idx;
									cab_d  = '0;
									btab_d = (cp.value == utwb_pkg::CP_TAB);
								end else if (bval_d) begin
									cab_d = cab_d + w9;
								end
								done = 1'b1;
							end else if (bval_d) begin
								if (n != 2'd3) begin
									res[n] = '{utwb_pkg::OUT_W'(ls_d),
										utwb_pkg::OUT_W'(sub_clamp(bpos_d, ls_d)), 1'b0};
									n = n + 2'd1;
								end
								ls_d    = btab_d ? bpos_d : inc_sat(bpos_d);
								cells_d = cab_d + utwb_pkg::CELL_W'(btab_d);
								bval_d  = 1'b0;
							end else if (idx <= ls_d) begin
								// glyph alone on its line
								cells_d = w9;
								done    = 1'b1;
							end else if (cp.value == utwb_pkg::CP_SPACE) begin
								held_d  = 1'b1;
								cells_d = '0;
								done    = 1'b1;
							end else begin
								// hard break before the glyph
								if (n != 2'd3) begin
									res[n] = '{utwb_pkg::OUT_W'(ls_d),
										utwb_pkg::OUT_W'(idx - ls_d), 1'b0};
									n = n + 2'd1;
								end
								ls_d    = idx;
								cells_d = '0;
							end
						end
					end
				end
			end
		end

		if (go && item.has) begin
			anyb_d = 1'b1;
		end

		// end of paragraph: final line unless wrapping is on and bytes came but none decoded, then back to reset
		if (go && item.last) begin
			if (wrap_width == '0) begin
				if (n != 2'd3) begin
					res[n] = '{utwb_pkg::OUT_W'(ls_d),
						utwb_pkg::OUT_W'(sub_clamp(cnt_d, ls_d)), 1'b1};
					n = n + 2'd1;
				end
			end else if (held_d) begin
				if (n != 2'd3) begin
					res[n] = '{utwb_pkg::OUT_W'(ls_d),
						utwb_pkg::OUT_W'(sub_clamp(sub_clamp(cnt_d, IDX_ONE), ls_d)), 1'b1};
					n = n + 2'd1;
				end
			end else if (!((cnt_d == '0) && anyb_d)) begin
				if (n != 2'd3) begin
					res[n] = '{utwb_pkg::OUT_W'(ls_d),
						utwb_pkg::OUT_W'(sub_clamp(cnt_d, ls_d)), 1'b1};
					n = n + 2'd1;
				end
			end
			cnt_d   = '0;
			ls_d    = '0;
			bpos_d  = '0;
			cells_d = '0;
			cab_d   = '0;
			btab_d  = 1'b0;
			bval_d  = 1'b0;
			held_d  = 1'b0;
			anyb_d  = 1'b0;
		end
	end

	assign res_cnt = n;

	// line state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q   <= '0;
			ls_q    <= '0;
			bpos_q  <= '0;
			cells_q <= '0;
			cab_q   <= '0;
			btab_q  <= 1'b0;
			bval_q  <= 1'b0;
			held_q  <= 1'b0;
			anyb_q  <= 1'b0;
		end else if (go) begin
			cnt_q   <= cnt_d;
			ls_q    <= ls_d;
			bpos_q  <= bpos_d;
			cells_q <= cells_d;
			cab_q   <= cab_d;
			btab_q  <= btab_d;
			bval_q  <= bval_d;
			held_q  <= held_d;
			anyb_q  <= anyb_d;
		end
	end

endmodule

### rtl/utwb_emit.sv
// result stage: holds up to three lines and sends them one per transfer
// depends on utwb_pkg
module utwb_emit (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             load,
	input  utwb_pkg::line_t                  res [utwb_pkg::MAX_LINES],
	input  logic [utwb_pkg::LINE_CNT_W-1:0]  res_cnt,
	output logic                             can_load,
	output logic                             line_valid,
	input  logic                             line_ready,
	output logic [utwb_pkg::OUT_W-1:0]       line_start,
	output logic [utwb_pkg::OUT_W-1:0]       line_length,
	output logic                             last_line
);

	utwb_pkg::line_t                 slot_s2 [utwb_pkg::MAX_LINES];
	logic [utwb_pkg::LINE_CNT_W-1:0] cnt_s2;
	logic                            take;

	assign line_valid  = (cnt_s2 != '0);
	assign take        = line_valid && line_ready;
	assign can_load    = (cnt_s2 == '0) || ((cnt_s2 == 2'd1) && line_ready);
	assign line_start  = slot_s2[0].start;
	assign line_length = slot_s2[0].length;
	assign last_line   = slot_s2[0].last;

	// occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_s2 <= '0;
		end else if (load) begin
			cnt_s2 <= res_cnt;
		end else if (take) begin
			cnt_s2 <= cnt_s2 - 2'd1;
		end
	end

	// line slots, shifted toward the port on each transfer
	always_ff @(posedge clk) begin
		if (load) begin
			slot_s2 <= res;
		end else if (take) begin
			for (int k = 0; k < utwb_pkg::MAX_LINES - 1; k++) begin
				slot_s2[k] <= slot_s2[k+1];
			end
		end
	end

endmodule

### rtl/utf8_word_wrap_line_breaker.sv
// top level: register port, input register, decoder, breaker and result stage
// depends on utwb_pkg, utwb_decode, utwb_wrap, utwb_emit
//
// channel  | handshake               | payload
// item     | item_valid, item_ready  | byte_value, has_byte, last_byte
// line     | line_valid, line_ready  | line_start, line_length, last_line
// config   | psel, penable, pwrite   | paddr, pwdata, prdata (wrap_width at 0x0)
//
// an item is taken into the input register and fully processed once the result stage
// can take its lines, one item per cycle unless the line port stalls; each item yields
// zero to three lines; the result stage sends one line per transfer, so an item with
// k lines keeps the input register waiting until its last line is taken
// reset clears all paragraph state; wrap_width returns to 80
// a stalled line port holds the input register and then item_ready
module utf8_word_wrap_line_breaker #(
	parameter int INDEX_BITS = utwb_pkg::INDEX_BITS_DEFAULT
) (
	input  logic                              clk,
	input  logic                              arst_n,
	// configuration
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [utwb_pkg::ADDR_W-1:0]       paddr,
	input  logic [utwb_pkg::DATA_W-1:0]       pwdata,
	output logic [utwb_pkg::DATA_W-1:0]       prdata,
	output logic                              pready,
	// bytes
	input  logic                              item_valid,
	output logic                              item_ready,
	input  logic [utwb_pkg::BYTE_W-1:0]       byte_value,
	input  logic                              has_byte,
	input  logic                              last_byte,
	// lines
	output logic                              line_valid,
	input  logic                              line_ready,
	output logic [utwb_pkg::OUT_W-1:0]        line_start,
	output logic [utwb_pkg::OUT_W-1:0]        line_length,
	output logic                              last_line
);

	logic [utwb_pkg::WIDTH_W-1:0]    wrap_width_q;
	logic [utwb_pkg::REG_IDX_W-1:0]  reg_idx;
	logic                            wr_en;
	utwb_pkg::item_t                 item_s1;
	logic                            valid_s1;
	logic                            go;
	logic                            can_load;
	utwb_pkg::cp_t                   cp;
	utwb_pkg::line_t                 res [utwb_pkg::MAX_LINES];
	logic [utwb_pkg::LINE_CNT_W-1:0] res_cnt;

	// register port
	assign reg_idx = paddr[utwb_pkg::ADDR_W-1:2];
	assign pready  = 1'b1;
	assign wr_en   = psel && penable && pwrite && (reg_idx == utwb_pkg::REG_WRAP_WIDTH);
	assign prdata  = (reg_idx == utwb_pkg::REG_WRAP_WIDTH) ?
		utwb_pkg::DATA_W'(wrap_width_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wrap_width_q <= utwb_pkg::WRAP_WIDTH_RESET;
		end else if (wr_en) begin
			wrap_width_q <= pwdata[utwb_pkg::WIDTH_W-1:0];
		end
	end

	// input register advances when the result stage can take its lines
	assign go         = valid_s1 && can_load;
	assign item_ready = !valid_s1 || can_load;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item_ready) begin
			valid_s1 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item_valid && item_ready) begin
			item_s1 <= '{byte_value, has_byte, last_byte};
		end
	end

	utwb_decode u_decode (
		.clk    (clk),
		.arst_n (arst_n),
		.go     (go),
		.item   (item_s1),
		.cp     (cp)
	);

	utwb_wrap #(
		.INDEX_BITS (INDEX_BITS)
	) u_wrap (
		.clk        (clk),
		.arst_n     (arst_n),
		.go         (go),
		.item       (item_s1),
		.cp         (cp),
		.wrap_width (wrap_width_q),
		.res        (res),
		.res_cnt    (res_cnt)
	);

	utwb_emit u_emit (
		.clk         (clk),
		.arst_n      (arst_n),
		.load        (go),
		.res         (res),
		.res_cnt     (res_cnt),
		.can_load    (can_load),
		.line_valid  (line_valid),
		.line_ready  (line_ready),
		.line_start  (line_start),
		.line_length (line_length),
		.last_line   (last_line)
	);

endmodule
